// ===== rtl/fsq_pkg.sv =====
// Shared types, sizes and helpers of the four-sum quadruple search block.
`default_nettype none
package fsq_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int MAX_RESULTS  = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int DATA_W       = 32;
  localparam int SUM_W        = DATA_W + 3;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [SUM_W-1:0]  wsum_t;

  typedef struct packed {
    word_t first_value;
    word_t second_value;
    word_t third_value;
    word_t fourth_value;
    logic  found;
    logic  last_result;
    logic  overflow;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_push_t;

  function automatic wsum_t sx(input word_t a);
    sx = {{(SUM_W - DATA_W){a[DATA_W-1]}}, a};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fsq_if.sv =====
// Channel interfaces of the four-sum quadruple search block.
`default_nettype none
interface fsq_in_if;
  import fsq_pkg::*;
  logic  valid;
  logic  ready;
  word_t element_value;
  logic  last_element;
  modport source (output valid, element_value, last_element, input ready);
  modport sink (input valid, element_value, last_element, output ready);
endinterface

interface fsq_cfg_if;
  import fsq_pkg::*;
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface fsq_out_if;
  import fsq_pkg::*;
  logic  valid;
  logic  ready;
  word_t first_value;
  word_t second_value;
  word_t third_value;
  word_t fourth_value;
  logic  found;
  logic  last_result;
  logic  overflow;
  modport source (output valid, first_value, second_value, third_value, fourth_value,
                  found, last_result, overflow, input ready);
  modport sink (input valid, first_value, second_value, third_value, fourth_value,
                found, last_result, overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/fsq_search.sv =====
// Front part: sorted insertion into the element store and the quadruple search.
`default_nettype none
module fsq_search (
  input  wire logic              clk,
  input  wire logic              rst_n,
  fsq_in_if.sink                 in_if,
  input  wire fsq_pkg::word_t    target,
  input  wire logic              q_full,
  output fsq_pkg::res_push_t     push
);
  import fsq_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_INS   = 16'b0000_0000_0000_0010,
    S_SN1   = 16'b0000_0000_0000_0100,
    S_SN2   = 16'b0000_0000_0000_1000,
    S_SN3   = 16'b0000_0000_0001_0000,
    S_I_RD  = 16'b0000_0000_0010_0000,
    S_I_CHK = 16'b0000_0000_0100_0000,
    S_I_SUM = 16'b0000_0000_1000_0000,
    S_J_RD  = 16'b0000_0001_0000_0000,
    S_J_CHK = 16'b0000_0010_0000_0000,
    S_J_SUM = 16'b0000_0100_0000_0000,
    S_K_RD  = 16'b0000_1000_0000_0000,
    S_K_CMP = 16'b0001_0000_0000_0000,
    S_SK_RD = 16'b0010_0000_0000_0000,
    S_SK_CMP = 16'b0100_0000_0000_0000,
    S_FIN   = 16'b1000_0000_0000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, l_r, l_nxt;
  logic [RES_CNT_W-1:0] emit_r, emit_nxt;
  logic                 pend_v_r, pend_v_nxt, over_r, over_nxt, last_r, last_nxt;
  result_t              pend_r, pend_nxt;
  word_t                v_r, v_nxt, sn1_r, sn1_nxt, sn2_r, sn2_nxt, sn3_r, sn3_nxt;
  word_t                si_r, si_nxt, s1_r, s1_nxt, sj_r, sj_nxt, sj1_r, sj1_nxt;
  word_t                prev_i_r, prev_i_nxt, prev_j_r, prev_j_nxt, sko_r, sko_nxt;
  word_t                slo_r, slo_nxt;
  wsum_t                pre_r, pre_nxt, tx, pre_c, sum_c;

  word_t                mem [MAX_ELEMENTS];
  word_t                rd_a, rd_b, wd;
  logic [IDX_W-1:0]     ra, rb, wa;
  logic                 we;
  logic                 i_more, j_more;

  assign in_if.ready = (state_r == S_IDLE);
  assign tx          = sx(target);
  assign pre_c       = sx(si_r) + sx(sj_r);
  assign sum_c       = pre_r + sx(rd_a) + sx(rd_b);
  assign i_more      = ({1'b0, i_r} + (CNT_W + 1)'(5)) <= {1'b0, cnt_r};
  assign j_more      = ({1'b0, j_r} + (CNT_W + 1)'(4)) <= {1'b0, cnt_r};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    l_nxt      = l_r;
    emit_nxt   = emit_r;
    pend_v_nxt = pend_v_r;
    over_nxt   = over_r;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    v_nxt      = v_r;
    sn1_nxt    = sn1_r;
    sn2_nxt    = sn2_r;
    sn3_nxt    = sn3_r;
    si_nxt     = si_r;
    s1_nxt     = s1_r;
    sj_nxt     = sj_r;
    sj1_nxt    = sj1_r;
    prev_i_nxt = prev_i_r;
    prev_j_nxt = prev_j_r;
    sko_nxt    = sko_r;
    slo_nxt    = slo_r;
    pre_nxt    = pre_r;
    ra         = '0;
    rb         = '0;
    we         = 1'b0;
    wa         = pos_r;
    wd         = v_r;
    push       = '0;
    unique case (state_r)
      S_IDLE: begin
        ra = IDX_W'(cnt_r - CNT_W'(1));
        if (in_if.valid) begin
          v_nxt    = in_if.element_value;
          last_nxt = in_if.last_element;
          if (cnt_r < CNT_W'(MAX_ELEMENTS)) begin
            pos_nxt   = cnt_r[IDX_W-1:0];
            state_nxt = S_INS;
          end else if (in_if.last_element) begin
            state_nxt = (cnt_r >= CNT_W'(4)) ? S_SN1 : S_FIN;
          end
        end
      end
      S_INS: begin
        ra = pos_r - IDX_W'(2);
        we = 1'b1;
        if (pos_r != '0 && rd_a > v_r) begin
          wd      = rd_a;
          pos_nxt = pos_r - IDX_W'(1);
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (last_r) begin
            state_nxt = (cnt_r >= CNT_W'(3)) ? S_SN1 : S_FIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SN1: begin
        ra        = IDX_W'(cnt_r - CNT_W'(1));
        rb        = IDX_W'(cnt_r - CNT_W'(2));
        i_nxt     = '0;
        state_nxt = S_SN2;
      end
      S_SN2: begin
        sn1_nxt   = rd_a;
        sn2_nxt   = rd_b;
        ra        = IDX_W'(cnt_r - CNT_W'(3));
        state_nxt = S_SN3;
      end
      S_SN3: begin
        sn3_nxt   = rd_a;
        ra        = i_r[IDX_W-1:0];
        rb        = IDX_W'(i_r + CNT_W'(1));
        state_nxt = S_I_CHK;
      end
      S_I_RD: begin
        ra        = i_r[IDX_W-1:0];
        rb        = IDX_W'(i_r + CNT_W'(1));
        state_nxt = S_I_CHK;
      end
      S_I_CHK: begin
        si_nxt     = rd_a;
        s1_nxt     = rd_b;
        prev_i_nxt = rd_a;
        ra         = IDX_W'(i_r + CNT_W'(2));
        rb         = IDX_W'(i_r + CNT_W'(3));
        if (i_r != '0 && rd_a == prev_i_r) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = i_more ? S_I_RD : S_FIN;
        end else begin
          state_nxt = S_I_SUM;
        end
      end
      S_I_SUM: begin
        if (sx(si_r) + sx(s1_r) + sx(rd_a) + sx(rd_b) > tx) begin
          state_nxt = S_FIN;
        end else if (sx(si_r) + sx(sn1_r) + sx(sn2_r) + sx(sn3_r) < tx) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = i_more ? S_I_RD : S_FIN;
        end else begin
          j_nxt     = i_r + CNT_W'(1);
          state_nxt = S_J_RD;
        end
      end
      S_J_RD: begin
        ra        = j_r[IDX_W-1:0];
        rb        = IDX_W'(j_r + CNT_W'(1));
        state_nxt = S_J_CHK;
      end
      S_J_CHK: begin
        sj_nxt     = rd_a;
        sj1_nxt    = rd_b;
        prev_j_nxt = rd_a;
        ra         = IDX_W'(j_r + CNT_W'(2));
        if (j_r != i_r + CNT_W'(1) && rd_a == prev_j_r) begin
          j_nxt = j_r + CNT_W'(1);
          if (j_more) begin
            state_nxt = S_J_RD;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = i_more ? S_I_RD : S_FIN;
          end
        end else begin
          state_nxt = S_J_SUM;
        end
      end
      S_J_SUM: begin
        if (pre_c + sx(sj1_r) + sx(rd_a) > tx) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = i_more ? S_I_RD : S_FIN;
        end else if (pre_c + sx(sn1_r) + sx(sn2_r) < tx) begin
          j_nxt = j_r + CNT_W'(1);
          if (j_more) begin
            state_nxt = S_J_RD;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = i_more ? S_I_RD : S_FIN;
          end
        end else begin
          pre_nxt   = pre_c;
          k_nxt     = j_r + CNT_W'(1);
          l_nxt     = cnt_r - CNT_W'(1);
          state_nxt = S_K_RD;
        end
      end
      S_K_RD: begin
        ra = k_r[IDX_W-1:0];
        rb = l_r[IDX_W-1:0];
        if (k_r < l_r) begin
          state_nxt = S_K_CMP;
        end else begin
          j_nxt = j_r + CNT_W'(1);
          if (j_more) begin
            state_nxt = S_J_RD;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = i_more ? S_I_RD : S_FIN;
          end
        end
      end
      S_K_CMP: begin
        ra = k_r[IDX_W-1:0];
        rb = l_r[IDX_W-1:0];
        if (sum_c == tx) begin
          if (emit_r == RES_CNT_W'(MAX_RESULTS)) begin
            over_nxt  = 1'b1;
            state_nxt = S_FIN;
          end else if (!(pend_v_r && q_full)) begin
            push.valid            = pend_v_r;
            push.res              = pend_r;
            pend_nxt.first_value  = si_r;
            pend_nxt.second_value = sj_r;
            pend_nxt.third_value  = rd_a;
            pend_nxt.fourth_value = rd_b;
            pend_nxt.found        = 1'b1;
            pend_nxt.last_result  = 1'b0;
            pend_nxt.overflow     = 1'b0;
            pend_v_nxt            = 1'b1;
            emit_nxt              = emit_r + RES_CNT_W'(1);
            sko_nxt               = rd_a;
            slo_nxt               = rd_b;
            k_nxt                 = k_r + CNT_W'(1);
            l_nxt                 = l_r - CNT_W'(1);
            state_nxt             = S_SK_RD;
          end
        end else if (sum_c < tx) begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_K_RD;
        end else begin
          l_nxt     = l_r - CNT_W'(1);
          state_nxt = S_K_RD;
        end
      end
      S_SK_RD: begin
        ra        = k_r[IDX_W-1:0];
        rb        = l_r[IDX_W-1:0];
        state_nxt = (k_r < l_r) ? S_SK_CMP : S_K_RD;
      end
      S_SK_CMP: begin
        if (rd_a == sko_r) begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_SK_RD;
        end else if (rd_b == slo_r) begin
          l_nxt     = l_r - CNT_W'(1);
          state_nxt = S_SK_RD;
        end else begin
          state_nxt = S_K_RD;
        end
      end
      S_FIN: begin
        if (!q_full) begin
          push.valid = 1'b1;
          if (pend_v_r) begin
            push.res          = pend_r;
            push.res.overflow = over_r;
          end
          push.res.last_result = 1'b1;
          cnt_nxt              = '0;
          pend_v_nxt           = 1'b0;
          emit_nxt             = '0;
          over_nxt             = 1'b0;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      emit_r   <= '0;
      pend_v_r <= 1'b0;
      over_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      emit_r   <= emit_nxt;
      pend_v_r <= pend_v_nxt;
      over_r   <= over_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    l_r      <= l_nxt;
    last_r   <= last_nxt;
    pend_r   <= pend_nxt;
    v_r      <= v_nxt;
    sn1_r    <= sn1_nxt;
    sn2_r    <= sn2_nxt;
    sn3_r    <= sn3_nxt;
    si_r     <= si_nxt;
    s1_r     <= s1_nxt;
    sj_r     <= sj_nxt;
    sj1_r    <= sj1_nxt;
    prev_i_r <= prev_i_nxt;
    prev_j_r <= prev_j_nxt;
    sko_r    <= sko_nxt;
    slo_r    <= slo_nxt;
    pre_r    <= pre_nxt;
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("pending result left over while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond store size");

  a_last_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && push.res.last_result |=> state_r == S_IDLE && cnt_r == '0)
    else $error("final result did not end the search");

endmodule
`default_nettype wire

// ===== rtl/fsq_queue.sv =====
// Back part: result queue between the search engine and the output channel.
`default_nettype none
module fsq_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fsq_pkg::res_push_t push,
  output logic                   full,
  fsq_out_if.source              out_if
);
  import fsq_pkg::*;

  result_t              entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, rp_r;
  logic [FIFO_AW:0]     count_r;
  logic                 pop;
  result_t              head;

  assign full   = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign pop    = out_if.valid && out_if.ready;
  assign head   = entry_r[rp_r];

  assign out_if.valid        = (count_r != '0);
  assign out_if.first_value  = head.first_value;
  assign out_if.second_value = head.second_value;
  assign out_if.third_value  = head.third_value;
  assign out_if.fourth_value = head.fourth_value;
  assign out_if.found        = head.found;
  assign out_if.last_result  = head.last_result;
  assign out_if.overflow     = head.overflow;

  always_ff @(posedge clk) begin
    if (push.valid && !full) begin
      entry_r[wp_r] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push.valid && !full) begin
        wp_r <= wp_r + FIFO_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FIFO_AW'(1);
      end
      count_r <= count_r + (FIFO_AW + 1)'(push.valid && !full) - (FIFO_AW + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/four_sum_unique_quadruples.sv =====
// Top level of the four-sum quadruple search block.
// Loading an element runs a sorted insertion walk that shifts each larger element up one place.
// The final element of a set of four or more starts a pointer walk over the single store memory,
// two reads a cycle, and results leave through a four-entry queue.
// Reset (synchronous, active low) empties the store and queue; the target resets to 0.
`default_nettype none
module four_sum_unique_quadruples (
  input  wire logic clk,
  input  wire logic rst_n,
  fsq_in_if.sink    in_if,
  fsq_cfg_if.sink   cfg_if,
  fsq_out_if.source out_if
);
  import fsq_pkg::*;

  word_t     target_r;
  res_push_t push;
  logic      q_full;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_if.valid) begin
      target_r <= cfg_if.data;
    end
  end

  fsq_search u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .target (target_r),
    .q_full (q_full),
    .push   (push)
  );

  fsq_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (q_full),
    .out_if (out_if)
  );

endmodule
`default_nettype wire

// ===== tb/sv/four_sum_unique_quadruples_tb.sv =====
// Self-checking testbench for the four-sum quadruple search block.
`timescale 1ns / 100ps

module four_sum_unique_quadruples_tb;
  import fsq_pkg::*;

  localparam int STALL_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int ITEM_GOAL = 410;

  class quad_scoreboard;
    longint  sorted_vals[MAX_ELEMENTS];
    int      count;
    longint  target;
    result_t quad_q[$];
    int      mismatches;
    int      results_seen;
    int      overflow_sets;

    function new();
      count = 0;
      target = 0;
      mismatches = 0;
      results_seen = 0;
      overflow_sets = 0;
    endfunction

    function void push_quad(longint a, longint b, longint c, longint d, bit hit);
      result_t r;
      r.first_value = word_t'(a);
      r.second_value = word_t'(b);
      r.third_value = word_t'(c);
      r.fourth_value = word_t'(d);
      r.found = hit;
      r.last_result = 1'b0;
      r.overflow = 1'b0;
      quad_q = {quad_q, r};
    endfunction

    function void note_element(word_t value, bit last);
      longint v;
      int pos, n, i, j, k, l, emitted;
      longint pre, total;
      bit over;
      v = value;
      emitted = 0;
      over = 0;
      if (count < MAX_ELEMENTS) begin
        pos = count;
        while (pos > 0 && sorted_vals[pos-1] > v) begin
          sorted_vals[pos] = sorted_vals[pos-1];
          pos--;
        end
        sorted_vals[pos] = v;
        count++;
      end
      if (!last) return;
      n = count;
      for (i = 0; i + 3 < n && !over; i++) begin
        if (i > 0 && sorted_vals[i] == sorted_vals[i-1]) continue;
        if (sorted_vals[i] + sorted_vals[i+1] + sorted_vals[i+2] + sorted_vals[i+3] > target)
          break;
        if (sorted_vals[i] + sorted_vals[n-1] + sorted_vals[n-2] + sorted_vals[n-3] < target)
          continue;
        for (j = i + 1; j + 2 < n && !over; j++) begin
          if (j > i + 1 && sorted_vals[j] == sorted_vals[j-1]) continue;
          pre = sorted_vals[i] + sorted_vals[j];
          if (pre + sorted_vals[j+1] + sorted_vals[j+2] > target) break;
          if (pre + sorted_vals[n-1] + sorted_vals[n-2] < target) continue;
          k = j + 1;
          l = n - 1;
          while (k < l && !over) begin
            total = pre + sorted_vals[k] + sorted_vals[l];
            if (total == target) begin
              if (emitted >= MAX_RESULTS) begin
                over = 1;
              end else begin
                push_quad(sorted_vals[i], sorted_vals[j], sorted_vals[k], sorted_vals[l], 1);
                emitted++;
                k++;
                l--;
                while (k < l && sorted_vals[k] == sorted_vals[k-1]) k++;
                while (k < l && sorted_vals[l] == sorted_vals[l+1]) l--;
              end
            end else if (total < target) begin
              k++;
            end else begin
              l--;
            end
          end
        end
      end
      if (emitted == 0) push_quad(0, 0, 0, 0, 0);
      quad_q[quad_q.size()-1].last_result = 1'b1;
      quad_q[quad_q.size()-1].overflow = over;
      if (over) overflow_sets++;
      count = 0;
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (quad_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %h at %0t", got, $realtime);
        return;
      end
      want = quad_q.pop_front();
      if (got.first_value !== want.first_value || got.second_value !== want.second_value ||
          got.third_value !== want.third_value || got.fourth_value !== want.fourth_value ||
          got.found !== want.found || got.last_result !== want.last_result ||
          got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d at %0t: expected %0d %0d %0d %0d f%b l%b o%b",
                   results_seen, $realtime, want.first_value, want.second_value,
                   want.third_value, want.fourth_value, want.found, want.last_result,
                   want.overflow);
          $display("       got %0d %0d %0d %0d f%b l%b o%b",
                   got.first_value, got.second_value, got.third_value,
                   got.fourth_value, got.found, got.last_result, got.overflow);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  fsq_in_if  in_if();
  fsq_cfg_if cfg_if();
  fsq_out_if out_if();

  four_sum_unique_quadruples dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .out_if (out_if)
  );

  quad_scoreboard quads = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int sets_sent = 0;
  int quiet_cycles = 0;
  result_t got_res;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        quads.note_element(in_if.element_value, in_if.last_element);
      if (out_if.valid && out_if.ready) begin
        got_res.first_value = out_if.first_value;
        got_res.second_value = out_if.second_value;
        got_res.third_value = out_if.third_value;
        got_res.fourth_value = out_if.fourth_value;
        got_res.found = out_if.found;
        got_res.last_result = out_if.last_result;
        got_res.overflow = out_if.overflow;
        quads.check_result(got_res);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", quads.quad_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_element(input word_t value, input bit last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.element_value <= value;
    in_if.last_element <= last;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    if (last) sets_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (quads.quad_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input word_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    quads.target = value;
  endtask

  task automatic send_set(input int n, input int spread, input int wide_pct);
    word_t v;
    for (int e = 0; e < n; e++) begin
      if ($urandom_range(99) < wide_pct) v = $urandom;
      else v = $urandom_range(2 * spread) - spread;
      send_element(v, e == n - 1);
    end
  endtask

  initial begin
    int pct;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.element_value <= '0;
    in_if.last_element <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Duplicates, a single element and a set of three.
    send_element(2, 0); send_element(-1, 0); send_element(0, 0);
    send_element(0, 0); send_element(1, 0); send_element(-2, 0);
    send_element(2, 1);
    send_element(5, 1);
    send_element(1, 0); send_element(-1, 0); send_element(0, 1);
    drain();
    write_target(32'sh7fffffff);
    send_element(32'sh7fffffff, 0); send_element(0, 0); send_element(0, 0);
    send_element(0, 1);
    send_element(32'sh7fffffff, 0); send_element(32'sh7fffffff, 0);
    send_element(32'sh7fffffff, 0); send_element(32'sh7fffffff, 1);
    drain();
    write_target(32'sh80000000);
    send_element(0, 0); send_element(32'sh80000000, 0); send_element(0, 0);
    send_element(0, 1);
    send_element(32'sh80000000, 0); send_element(32'sh80000000, 0);
    send_element(32'sh80000000, 0); send_element(32'sh80000000, 1);
    drain();

    // Too many matches, and elements beyond a full store.
    write_target(0);
    for (int e = 0; e < 66; e++) send_element(e - 32, e == 65);
    drain();

    while (items_sent < ITEM_GOAL) begin
      pct = (items_sent * 4) / ITEM_GOAL;
      send_idle_pct = (pct == 1 || pct == 3) ? (pct == 3 ? 20 : 87) : 0;
      recv_stall_pct = (pct == 2 || pct == 3) ? (pct == 3 ? 20 : 87) : 0;
      if (sets_sent % 5 == 0) begin
        drain();
        if ($urandom_range(9) == 0) write_target($urandom);
        else write_target($urandom_range(40) - 20);
      end
      if ($urandom_range(19) == 0) send_set($urandom_range(30, 12), 12, 5);
      else send_set($urandom_range(12, 1), 10, 15);
    end
    drain();

    $display("Sent %0d elements in %0d sets, checked %0d results, %0d sets overflowed.",
             items_sent, sets_sent, quads.results_seen, quads.overflow_sets);
    if (quads.mismatches == 0 && quads.quad_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", quads.mismatches, quads.quad_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
